// ===== rtl/lpcp_pkg.sv =====
package lpcp_pkg;

  localparam int unsigned IMAGE_WIDTH  = 640;
  localparam int unsigned IMAGE_HEIGHT = 480;

  localparam int CW     = 34;
  localparam int CSTEPS = 16;
  localparam int NW     = 60;
  localparam int DENW   = 48;
  localparam int QW     = 12;
  localparam int DSTEPS = QW + 1;

  localparam logic [15:0]        RANGE_MIN = 16'd410;
  localparam logic [15:0]        RANGE_MAX = 16'd24576;
  localparam logic signed [17:0] PI_Q      = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q  = 18'sd51472;
  localparam logic signed [17:0] QLIM      = 18'sd6434;
  localparam logic signed [CW-1:0] CORDIC_X0 = CW'(652032874);

  localparam logic [2:0] REG_FRONT_ANGLE  = 3'd0;
  localparam logic [2:0] REG_FRONT_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FRONT_SCALE  = 3'd2;
  localparam logic [2:0] REG_REAR_ANGLE   = 3'd3;
  localparam logic [2:0] REG_REAR_HEIGHT  = 3'd4;
  localparam logic [2:0] REG_REAR_SCALE   = 3'd5;

  localparam logic signed [NW-1:0] FX_K   [2] = '{NW'(708418), NW'(705052)};
  localparam logic signed [NW-1:0] CXS_K  [2] = '{NW'(64'sd310005 * 64'sd16384),
                                                  NW'(64'sd316681 * 64'sd16384)};
  localparam logic signed [NW-1:0] FY16_K [2] = '{NW'(64'sd706711 * 64'sd16),
                                                  NW'(64'sd703592 * 64'sd16)};
  localparam logic signed [NW-1:0] CY_K   [2] = '{NW'(254354), NW'(251951)};
  localparam logic signed [NW-1:0] DEN_U_K = NW'(64'sd1000 * 64'sd16384);
  localparam logic signed [NW-1:0] DEN_V_K = NW'(1000);

  function automatic logic signed [CW-1:0] atan_f(input logic [3:0] i);
    logic signed [CW-1:0] r;
    unique case (i)
      4'd0:  r = CW'(843314856);
      4'd1:  r = CW'(497837829);
      4'd2:  r = CW'(263043836);
      4'd3:  r = CW'(133525158);
      4'd4:  r = CW'(67021686);
      4'd5:  r = CW'(33543515);
      4'd6:  r = CW'(16775850);
      4'd7:  r = CW'(8388437);
      4'd8:  r = CW'(4194282);
      4'd9:  r = CW'(2097149);
      4'd10: r = CW'(1048575);
      4'd11: r = CW'(524287);
      4'd12: r = CW'(262143);
      4'd13: r = CW'(131071);
      4'd14: r = CW'(65535);
      4'd15: r = CW'(32767);
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic                 act;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cord_cam_t;

  typedef struct packed {
    logic            last;
    logic [15:0]     pt_range;
    cord_cam_t [1:0] cam;
  } cord_t;

  typedef struct packed {
    logic [NW-1:0]   rem;
    logic [DENW-1:0] den;
    logic [QW:0]     q;
    logic            neg;
  } div_lane_t;

  typedef struct packed {
    logic            last;
    logic [1:0]      ok;
    div_lane_t [3:0] lane;
  } div_t;

endpackage

// ===== rtl/lpcp_in_if.sv =====
interface lpcp_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        point_range;
  logic signed [15:0] point_angle;
  logic               last_of_scan;

  modport source (output valid, output point_range, output point_angle,
                  output last_of_scan, input ready);
  modport sink (input valid, input point_range, input point_angle,
                input last_of_scan, output ready);
endinterface

// ===== rtl/lpcp_out_if.sv =====
interface lpcp_out_if;
  logic       valid;
  logic       ready;
  logic       front_hit;
  logic [9:0] front_col;
  logic [8:0] front_row;
  logic       rear_hit;
  logic [9:0] rear_col;
  logic [8:0] rear_row;
  logic       scan_end;

  modport source (output valid, output front_hit, output front_col, output front_row,
                  output rear_hit, output rear_col, output rear_row, output scan_end,
                  input ready);
  modport sink (input valid, input front_hit, input front_col, input front_row,
                input rear_hit, input rear_col, input rear_row, input scan_end,
                output ready);
endinterface

// ===== rtl/lpcp_cfg_if.sv =====
interface lpcp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lpcp_cordic_cell.sv =====
module lpcp_cordic_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [3:0]        iter_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  lpcp_pkg::cord_t   data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output lpcp_pkg::cord_t   data_o
);
  import lpcp_pkg::*;

  logic                 valid_q;
  cord_t                data_q, data_d;
  logic signed [CW-1:0] xs [2];
  logic signed [CW-1:0] ys [2];
  logic signed [CW-1:0] at;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign at      = atan_f(iter_i);

  always_comb begin
    data_d = data_i;
    for (int k = 0; k < 2; k++) begin
      xs[k] = $signed(data_i.cam[k].x) >>> iter_i;
      ys[k] = $signed(data_i.cam[k].y) >>> iter_i;
      if (!data_i.cam[k].z[CW-1]) begin
        data_d.cam[k].x = data_i.cam[k].x - ys[k];
        data_d.cam[k].y = data_i.cam[k].y + xs[k];
        data_d.cam[k].z = data_i.cam[k].z - at;
      end else begin
        data_d.cam[k].x = data_i.cam[k].x + ys[k];
        data_d.cam[k].y = data_i.cam[k].y - xs[k];
        data_d.cam[k].z = data_i.cam[k].z + at;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/lpcp_div_cell.sv =====
module lpcp_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [3:0]      shift_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  lpcp_pkg::div_t  data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output lpcp_pkg::div_t  data_o
);
  import lpcp_pkg::*;

  logic          valid_q;
  div_t          data_q, data_d;
  logic [NW-1:0] dsh [4];

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    data_d = data_i;
    for (int l = 0; l < 4; l++) begin
      dsh[l] = NW'(data_i.lane[l].den) << shift_i;
      if (data_i.lane[l].rem >= dsh[l]) begin
        data_d.lane[l].rem = data_i.lane[l].rem - dsh[l];
        data_d.lane[l].q   = data_i.lane[l].q | ((QW+1)'(1) << shift_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/lidar_point_camera_projection_unit.sv =====
// Projects each polar lidar point into a front and a rear pinhole camera and reports the
// pixel hit, column and row for both. One point is taken per cycle and one result leaves
// per cycle while the result channel is ready; a point's result passes the input register,
// the 16-cell CORDIC chain, two multiply stages, a sign stage, the 13-cell quotient chain
// and the output register. Every stage stalls on its own, so bubbles close up and new
// points enter while a result waits at the output. Configuration writes take effect at
// once; the user must make them while no point is in flight; the block does not enforce it.
module lidar_point_camera_projection_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpcp_in_if.sink    point_i,
  lpcp_out_if.source result_o,
  lpcp_cfg_if.sink   cfg_i
);
  import lpcp_pkg::*;

  typedef struct packed {
    logic        act;
    logic signed [23:0] c;
    logic signed [39:0] p1;
    logic signed [40:0] p2;
    logic signed [31:0] sh;
  } m1_cam_t;

  typedef struct packed {
    logic            last;
    m1_cam_t [1:0]   cam;
  } m1_t;

  typedef struct packed {
    logic                 ok;
    logic signed [NW-1:0] num_u;
    logic signed [NW-1:0] den_u;
    logic signed [NW-1:0] num_v;
    logic signed [NW-1:0] den_v;
  } m2_cam_t;

  typedef struct packed {
    logic          last;
    m2_cam_t [1:0] cam;
  } m2_t;

  typedef struct packed {
    logic            last;
    logic [1:0]      hit;
    logic [1:0][9:0] col;
    logic [1:0][8:0] row;
  } res_t;

  localparam logic [QW:0] W_LIM = (QW+1)'(IMAGE_WIDTH);
  localparam logic [QW:0] H_LIM = (QW+1)'(IMAGE_HEIGHT);

  // configuration
  logic signed [14:0] f_ang_q, r_ang_q;
  logic signed [15:0] f_hgt_q, r_hgt_q;
  logic [14:0]        f_scl_q, r_scl_q;
  logic [14:0]        scl [2];
  logic signed [15:0] hgt [2];

  assign cfg_i.ready = 1'b1;
  assign scl[0] = f_scl_q;
  assign scl[1] = r_scl_q;
  assign hgt[0] = f_hgt_q;
  assign hgt[1] = r_hgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_ang_q <= '0;
      f_hgt_q <= -16'sd819;
      f_scl_q <= 15'd16384;
      r_ang_q <= '0;
      r_hgt_q <= -16'sd819;
      r_scl_q <= 15'd16384;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_FRONT_ANGLE:  f_ang_q <= cfg_i.data[14:0];
        REG_FRONT_HEIGHT: f_hgt_q <= cfg_i.data;
        REG_FRONT_SCALE:  f_scl_q <= cfg_i.data[14:0];
        REG_REAR_ANGLE:   r_ang_q <= cfg_i.data[14:0];
        REG_REAR_HEIGHT:  r_hgt_q <= cfg_i.data;
        REG_REAR_SCALE:   r_scl_q <= cfg_i.data[14:0];
        default: ;
      endcase
    end
  end

  // front end: range gate, angle shift and wrap, window
  logic               fe_v_q, fe_rdy;
  cord_t              fe_q, fe_d;
  logic               rok;
  logic signed [17:0] af, ar0, ar;

  always_comb begin
    rok = (point_i.point_range >= RANGE_MIN) && (point_i.point_range <= RANGE_MAX);
    af  = 18'(point_i.point_angle) + 18'(f_ang_q);
    ar0 = 18'(point_i.point_angle) - PI_Q + 18'(r_ang_q);
    priority if (ar0 > PI_Q) begin
      ar = ar0 - TWO_PI_Q;
    end else if (ar0 < -PI_Q) begin
      ar = ar0 + TWO_PI_Q;
    end else begin
      ar = ar0;
    end
    fe_d.last       = point_i.last_of_scan;
    fe_d.pt_range   = point_i.point_range;
    fe_d.cam[0].act = rok && (af > -QLIM) && (af < QLIM);
    fe_d.cam[0].x   = CORDIC_X0;
    fe_d.cam[0].y   = '0;
    fe_d.cam[0].z   = CW'(af) <<< 17;
    fe_d.cam[1].act = rok && (ar > -QLIM) && (ar < QLIM);
    fe_d.cam[1].x   = CORDIC_X0;
    fe_d.cam[1].y   = '0;
    fe_d.cam[1].z   = CW'(ar) <<< 17;
  end

  // CORDIC chain
  cord_t         cv [CSTEPS+1];
  logic [CSTEPS:0] cvv, crr;
  logic          m1_rdy;

  assign point_i.ready = fe_rdy;
  assign fe_rdy        = !fe_v_q || crr[0];
  assign cv[0]         = fe_q;
  assign cvv[0]        = fe_v_q;
  assign crr[CSTEPS]   = m1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_v_q <= 1'b0;
    end else if (fe_rdy) begin
      fe_v_q <= point_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fe_rdy && point_i.valid) begin
      fe_q <= fe_d;
    end
  end

  for (genvar j = 0; j < CSTEPS; j++) begin : g_cordic
    lpcp_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .iter_i  (4'(j)),
      .valid_i (cvv[j]),
      .ready_o (crr[j]),
      .data_i  (cv[j]),
      .valid_o (cvv[j+1]),
      .ready_i (crr[j+1]),
      .data_o  (cv[j+1])
    );
  end

  // multiply stage 1
  logic               m1_v_q, m2_rdy;
  m1_t                m1_q, m1_d;
  logic signed [23:0] cc [2];
  logic signed [23:0] sn [2];

  assign m1_rdy = !m1_v_q || m2_rdy;

  always_comb begin
    m1_d.last = cv[CSTEPS].last;
    for (int k = 0; k < 2; k++) begin
      cc[k] = 24'($signed(cv[CSTEPS].cam[k].x) >>> 10);
      sn[k] = 24'($signed(cv[CSTEPS].cam[k].y) >>> 10);
      m1_d.cam[k].act = cv[CSTEPS].cam[k].act;
      m1_d.cam[k].c   = cc[k];
      m1_d.cam[k].p1  = 40'($signed({1'b0, scl[k]})) * 40'(sn[k]);
      m1_d.cam[k].p2  = 41'($signed({1'b0, cv[CSTEPS].pt_range})) * 41'(cc[k]);
      m1_d.cam[k].sh  = 32'($signed({1'b0, scl[k]})) * 32'(hgt[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (m1_rdy) begin
      m1_v_q <= cvv[CSTEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (m1_rdy && cvv[CSTEPS]) begin
      m1_q <= m1_d;
    end
  end

  // multiply stage 2: numerators and denominators
  logic m2_v_q, m3_rdy;
  m2_t  m2_q, m2_d;

  assign m2_rdy = !m2_v_q || m3_rdy;

  always_comb begin
    m2_d.last = m1_q.last;
    for (int k = 0; k < 2; k++) begin
      m2_d.cam[k].ok    = m1_q.cam[k].act && !m1_q.cam[k].c[23] && (m1_q.cam[k].c != '0);
      m2_d.cam[k].num_u = FX_K[k] * NW'(m1_q.cam[k].p1) + CXS_K[k] * NW'(m1_q.cam[k].c);
      m2_d.cam[k].den_u = DEN_U_K * NW'(m1_q.cam[k].c);
      m2_d.cam[k].num_v = FY16_K[k] * NW'(m1_q.cam[k].sh) + CY_K[k] * NW'(m1_q.cam[k].p2);
      m2_d.cam[k].den_v = DEN_V_K * NW'(m1_q.cam[k].p2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (m2_rdy) begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m2_rdy && m1_v_q) begin
      m2_q <= m2_d;
    end
  end

  // stage 3: magnitude and sign for the quotient chain
  logic m3_v_q;
  div_t m3_q, m3_d;
  div_t dv [DSTEPS+1];
  logic [DSTEPS:0] dvv, drr;
  logic out_rdy;

  assign m3_rdy = !m3_v_q || drr[0];

  always_comb begin
    m3_d.last = m2_q.last;
    for (int k = 0; k < 2; k++) begin
      m3_d.ok[k]           = m2_q.cam[k].ok;
      m3_d.lane[2*k].neg   = m2_q.cam[k].num_u[NW-1];
      m3_d.lane[2*k].rem   = m2_q.cam[k].num_u[NW-1] ? NW'(-m2_q.cam[k].num_u)
                                                      : NW'(m2_q.cam[k].num_u);
      m3_d.lane[2*k].den   = m2_q.cam[k].den_u[DENW-1:0];
      m3_d.lane[2*k].q     = '0;
      m3_d.lane[2*k+1].neg = m2_q.cam[k].num_v[NW-1];
      m3_d.lane[2*k+1].rem = m2_q.cam[k].num_v[NW-1] ? NW'(-m2_q.cam[k].num_v)
                                                      : NW'(m2_q.cam[k].num_v);
      m3_d.lane[2*k+1].den = m2_q.cam[k].den_v[DENW-1:0];
      m3_d.lane[2*k+1].q   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_v_q <= 1'b0;
    end else if (m3_rdy) begin
      m3_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m3_rdy && m2_v_q) begin
      m3_q <= m3_d;
    end
  end

  // quotient chain, one bit per cell
  assign dv[0]        = m3_q;
  assign dvv[0]       = m3_v_q;
  assign drr[DSTEPS]  = out_rdy;

  for (genvar j = 0; j < DSTEPS; j++) begin : g_div
    lpcp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (4'(QW - j)),
      .valid_i (dvv[j]),
      .ready_o (drr[j]),
      .data_i  (dv[j]),
      .valid_o (dvv[j+1]),
      .ready_i (drr[j+1]),
      .data_o  (dv[j+1])
    );
  end

  // output register
  logic        out_v_q;
  res_t        out_q, out_d;
  logic [QW:0] qc [2];
  logic [QW:0] qr [2];
  logic        hc [2];
  logic        hr [2];

  assign out_rdy = !out_v_q || result_o.ready;

  always_comb begin
    out_d.last = dv[DSTEPS].last;
    for (int k = 0; k < 2; k++) begin
      qc[k] = dv[DSTEPS].lane[2*k].q;
      qr[k] = dv[DSTEPS].lane[2*k+1].q;
      hc[k] = (qc[k] < W_LIM) && (!dv[DSTEPS].lane[2*k].neg || (qc[k] == '0));
      hr[k] = (qr[k] < H_LIM) && (!dv[DSTEPS].lane[2*k+1].neg || (qr[k] == '0));
      out_d.hit[k] = dv[DSTEPS].ok[k] && hc[k] && hr[k];
      out_d.col[k] = out_d.hit[k] ? qc[k][9:0] : '0;
      out_d.row[k] = out_d.hit[k] ? qr[k][8:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= dvv[DSTEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && dvv[DSTEPS]) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid     = out_v_q;
  assign result_o.front_hit = out_q.hit[0];
  assign result_o.front_col = out_q.col[0];
  assign result_o.front_row = out_q.row[0];
  assign result_o.rear_hit  = out_q.hit[1];
  assign result_o.rear_col  = out_q.col[1];
  assign result_o.rear_row  = out_q.row[1];
  assign result_o.scan_end  = out_q.last;

endmodule

// ===== dv/lidar_point_camera_projection_unit_tb.sv =====
`timescale 1ns / 1ps

module lidar_point_camera_projection_unit_tb;
  import lpcp_pkg::*;

  typedef struct {
    bit       front_hit;
    bit [9:0] front_col;
    bit [8:0] front_row;
    bit       rear_hit;
    bit [9:0] rear_col;
    bit [8:0] rear_row;
    bit       scan_end;
  } pixel_t;

  class projection_scoreboard;
    longint      front_ang, front_h, front_s, rear_ang, rear_h, rear_s;
    pixel_t      pending_q[$];
    int unsigned errors;

    function void set_defaults();
      front_ang = 0; front_h = -819; front_s = 16384;
      rear_ang  = 0; rear_h  = -819; rear_s  = 16384;
    endfunction

    function void write_reg(bit [2:0] idx, bit [15:0] val);
      case (idx)
        REG_FRONT_ANGLE:  front_ang = longint'($signed(val[14:0]));
        REG_FRONT_HEIGHT: front_h   = longint'($signed(val));
        REG_FRONT_SCALE:  front_s   = longint'(val[14:0]);
        REG_REAR_ANGLE:   rear_ang  = longint'($signed(val[14:0]));
        REG_REAR_HEIGHT:  rear_h    = longint'($signed(val));
        REG_REAR_SCALE:   rear_s    = longint'(val[14:0]);
        default: ;
      endcase
    endfunction

    function bit pinhole(longint a, longint d, longint s, longint h, longint fx,
                         longint cx, longint fy, longint cy,
                         output bit [9:0] col, output bit [8:0] row);
      longint atan_k[16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                             33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                             524287, 262143, 131071, 65535, 32767};
      longint x, y, z, xs, ys, c, sn, u, v;
      x = 652032874; y = 0; z = a * 131072;
      col = '0; row = '0;
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_k[i];
        end else begin
          x += ys; y -= xs; z += atan_k[i];
        end
      end
      c = x >>> 10;
      sn = y >>> 10;
      if (c <= 0) return 0;
      u = (fx * s * sn + cx * 16384 * c) / (1000 * 16384 * c);
      v = (fy * s * h * 16 + cy * d * c) / (1000 * d * c);
      if (u < 0 || u >= IMAGE_WIDTH || v < 0 || v >= IMAGE_HEIGHT) return 0;
      col = u[9:0];
      row = v[8:0];
      return 1;
    endfunction

    function void note_point(bit [15:0] rng, bit [15:0] ang, bit last);
      pixel_t e;
      longint d, af, ar;
      e = '{default: 0};
      e.scan_end = last;
      d = longint'(rng);
      if (d >= 410 && d <= 24576) begin
        af = longint'($signed(ang)) + front_ang;
        if (af > -6434 && af < 6434)
          e.front_hit = pinhole(af, d, front_s, front_h, 708418, 310005, 706711, 254354,
                                e.front_col, e.front_row);
        ar = longint'($signed(ang)) - 25736 + rear_ang;
        while (ar > 25736) ar -= 51472;
        while (ar < -25736) ar += 51472;
        if (ar > -6434 && ar < 6434)
          e.rear_hit = pinhole(ar, d, rear_s, rear_h, 705052, 316681, 703592, 251951,
                               e.rear_col, e.rear_row);
      end
      pending_q.insert(pending_q.size(), e);
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(pixel_t got);
      pixel_t e;
      if (pending_q.size() == 0) begin
        report("result beat with no point outstanding");
        return;
      end
      e = pending_q.pop_front();
      if (got.front_hit != e.front_hit) report($sformatf("front_hit %0d exp %0d",
                                               got.front_hit, e.front_hit));
      if (got.front_col != e.front_col) report($sformatf("front_col %0d exp %0d",
                                               got.front_col, e.front_col));
      if (got.front_row != e.front_row) report($sformatf("front_row %0d exp %0d",
                                               got.front_row, e.front_row));
      if (got.rear_hit != e.rear_hit) report($sformatf("rear_hit %0d exp %0d",
                                             got.rear_hit, e.rear_hit));
      if (got.rear_col != e.rear_col) report($sformatf("rear_col %0d exp %0d",
                                             got.rear_col, e.rear_col));
      if (got.rear_row != e.rear_row) report($sformatf("rear_row %0d exp %0d",
                                             got.rear_row, e.rear_row));
      if (got.scan_end != e.scan_end) report($sformatf("scan_end %0d exp %0d",
                                             got.scan_end, e.scan_end));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   burst;

  lpcp_in_if  point_if ();
  lpcp_out_if result_if ();
  lpcp_cfg_if cfg_if ();

  lidar_point_camera_projection_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_i  (point_if.sink),
    .result_o (result_if.source),
    .cfg_i    (cfg_if.sink)
  );

  projection_scoreboard sb = new();

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    pixel_t got;
    if (rst_ni && point_if.valid && point_if.ready)
      sb.note_point(point_if.point_range, point_if.point_angle, point_if.last_of_scan);
    if (rst_ni && result_if.valid && result_if.ready) begin
      got.front_hit = result_if.front_hit;
      got.front_col = result_if.front_col;
      got.front_row = result_if.front_row;
      got.rear_hit  = result_if.rear_hit;
      got.rear_col  = result_if.rear_col;
      got.rear_row  = result_if.rear_row;
      got.scan_end  = result_if.scan_end;
      sb.check_result(got);
    end
  end

  initial begin
    int unsigned stall;
    result_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
    end
  end

  task automatic send_point(bit [15:0] rng, bit [15:0] ang, bit last);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      point_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    point_if.valid        <= 1'b1;
    point_if.point_range  <= rng;
    point_if.point_angle  <= ang;
    point_if.last_of_scan <= last;
    do @(posedge clk_i); while (!point_if.ready);
  endtask

  task automatic drain();
    point_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(bit [2:0] idx, bit [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, val);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_point();
    int unsigned kind;
    int          a;
    bit [15:0]   rng;
    kind = $urandom_range(0, 9);
    if (kind < 7) rng = 16'($urandom_range(410, (kind < 4) ? 8192 : 24576));
    else rng = 16'($urandom);
    case ($urandom_range(0, 3))
      0: a = $urandom_range(0, 12868) - 6434;
      1: a = $urandom_range(0, 12868) + 25736 - 6434 - ((kind & 1) ? 51472 : 0);
      2: a = $urandom_range(0, 51472) - 25736;
      default: a = $urandom_range(0, 65535) - 32768;
    endcase
    send_point(rng, 16'(a), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_config(bit extreme);
    bit [15:0] v;
    for (int i = 0; i < 8; i++) begin
      if (extreme) begin
        case (i)
          0, 3: v = $urandom_range(0, 1) ? 16'(8192) : 16'(-8192);
          1, 4: v = $urandom_range(0, 1) ? 16'(16384) : 16'(-16384);
          2, 5: v = $urandom_range(0, 1) ? 16'(32767) : 16'(0);
          default: v = 16'($urandom);
        endcase
      end else begin
        case (i)
          0, 3: v = 16'($urandom_range(0, 1600) - 800);
          1, 4: v = 16'($urandom_range(0, 4000) - 2000);
          2, 5: v = 16'($urandom_range(8000, 24000));
          default: v = 16'($urandom);
        endcase
        if ($urandom_range(0, 9) == 0) v = 16'($urandom);
      end
      write_reg(3'(i), v);
    end
  endtask

  initial begin
    bit [15:0] ranges[6] = '{16'd0, 16'd409, 16'd410, 16'd24576, 16'd24577, 16'd65535};
    bit [15:0] angles[10] = '{16'd0, 16'd6433, -16'sd6433, 16'd6434, -16'sd6434,
                              16'd25736, -16'sd25736, 16'h8000, 16'h7FFF, 16'd20000};
    rst_ni = 1'b0;
    point_if.valid        <= 1'b0;
    point_if.point_range  <= '0;
    point_if.point_angle  <= '0;
    point_if.last_of_scan <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= '0;
    sb.set_defaults();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (ranges[i]) send_point(ranges[i], 16'd0, i[0]);
    foreach (angles[i]) send_point(16'd4096, angles[i], i[0]);
    send_point(16'd410, 16'd25736, 1'b1);
    send_point(16'd24576, 16'd3000, 1'b0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      burst = (ph % 4 == 3);
      random_config(ph % 3 == 1);
      for (int n = 0; n < 50; n++) random_point();
      drain();
    end

    if (sb.pending_q.size() != 0) sb.report("results still outstanding at end");
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
